[rtl/core/armd_pkg.sv]
// Shared constants, types and state encodings for the RMS dBFS level meter.
// No dependencies; imported by every module of the block but the checker.
package armd_pkg;

	localparam int COUNT_BITS = 20;
	localparam int SUM_W      = COUNT_BITS + 31;
	localparam int CNT_W      = COUNT_BITS + 1;
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 31;

	localparam int NORM_W  = 64;
	localparam int POS_W   = 6;
	localparam int FRAC_W  = 16;
	localparam int LOG_W   = POS_W + FRAC_W;
	localparam int MANT_W  = 31;
	localparam int STEP_W  = 3;
	localparam int ITER_W  = 4;

	localparam int DIFF_W  = LOG_W + 1;
	localparam int SCALE_W = 25;
	localparam int PROD_W  = DIFF_W + SCALE_W;
	localparam int RND_SH  = 32;
	localparam int RND_W   = PROD_W + 1 - RND_SH;
	localparam int LEVEL_W = 15;

	localparam logic [SCALE_W-1:0] CENTI_DB_PER_LOG2 = SCALE_W'(19728302);
	localparam logic [DIFF_W-1:0]  TOP_OFFSET        = DIFF_W'(30 << FRAC_W);
	localparam logic [RND_W-1:0]   MAX_ATTEN         = RND_W'(16000);
	localparam logic [LEVEL_W-1:0] FLOOR_LEVEL       = LEVEL_W'(-10000);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} win_t;

	typedef struct packed {
		logic              start;
		logic [NORM_W-1:0] x;
	} log_req_t;

	typedef struct packed {
		logic             done;
		logic [LOG_W-1:0] value;
	} log_rsp_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_SQR,
		L_DONE
	} log_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SS,
		B_LS,
		B_SN,
		B_LN,
		B_MUL,
		B_RND,
		B_OUT
	} back_state_t;

endpackage

[rtl/core/armd_front.sv]
// Front end: accepts sample beats, squares them and keeps saturating sums.
// Pushes each closed window's sum and count into the queue. Uses armd_pkg.
module armd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [armd_pkg::SAMPLE_W-1:0]      in_sample,
	input  logic                               in_last,
	output logic                               push,
	output armd_pkg::win_t                     push_data,
	input  logic                               q_full
);
	import armd_pkg::*;

	logic                valid_s1;
	logic                last_s1;
	logic [SQ_W-1:0]     sq_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SAMPLE_W-1:0] mag;
	logic [2*SAMPLE_W-1:0] sq_full;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    cnt_next;
	logic                advance;

	assign mag      = in_sample[SAMPLE_W-1]
		? SAMPLE_W'((SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, in_sample}) : in_sample;
	assign sq_full  = mag * mag;
	assign advance  = valid_s1 && (!last_s1 || !q_full);
	assign in_ready = !valid_s1 || advance;

	assign sum_add  = {1'b0, sum_q} + (SUM_W+1)'(sq_s1);
	assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign cnt_next = cnt_q[CNT_W-1] ? cnt_q : cnt_q + CNT_W'(1);

	assign push           = advance && last_s1;
	assign push_data.sum  = sum_next;
	assign push_data.cnt  = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sq_s1   <= sq_full[SQ_W-1:0];
			last_s1 <= in_last;
		end
	end

endmodule

[rtl/core/armd_queue.sv]
// Two-entry queue of closed windows between front and back end.
// Uses armd_pkg for the entry type.
module armd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  armd_pkg::win_t wdata,
	output logic           full,
	output logic           rd_valid,
	output armd_pkg::win_t rd_data,
	input  logic           rd_ready
);
	import armd_pkg::*;

	win_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign full     = fill_q == 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/armd_log2.sv]
// Iterative log2 unit, Q.16: six binary normalize steps, then sixteen
// squarings of the Q1.30 mantissa, one per cycle. Uses armd_pkg.
module armd_log2 (
	input  logic               clk,
	input  logic               arst_n,
	input  armd_pkg::log_req_t req,
	output armd_pkg::log_rsp_t rsp
);
	import armd_pkg::*;

	log_state_t          state_q;
	log_state_t          state_d;
	logic [NORM_W-1:0]   norm_q;
	logic [POS_W-1:0]    pos_q;
	logic [STEP_W-1:0]   step_q;
	logic [MANT_W-1:0]   m_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [ITER_W-1:0]   it_q;

	logic [POS_W:0]      shamt;
	logic                top_zero;
	logic [NORM_W-1:0]   norm_next;
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]     t;
	logic                norm_last;
	logic                sqr_last;

	assign shamt     = (POS_W+1)'(NORM_W / 2) >> step_q;
	assign top_zero  = (norm_q >> ((POS_W+1)'(NORM_W) - shamt)) == '0;
	assign norm_next = top_zero ? norm_q << shamt : norm_q;
	assign norm_last = step_q == STEP_W'(POS_W - 1);
	assign sq        = m_q * m_q;
	assign t         = sq[2*MANT_W-1:30];
	assign sqr_last  = it_q == ITER_W'(FRAC_W - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE: if (req.start) state_d = L_NORM;
			L_NORM: if (norm_last) state_d = L_SQR;
			L_SQR:  if (sqr_last) state_d = L_DONE;
			L_DONE: state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = state_q == L_DONE;
		rsp.value = {pos_q, frac_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				norm_q <= req.x;
				pos_q  <= POS_W'(NORM_W - 1);
				step_q <= '0;
			end
			L_NORM: begin
				norm_q <= norm_next;
				if (top_zero) begin
					pos_q <= pos_q - shamt[POS_W-1:0];
				end
				step_q <= step_q + STEP_W'(1);
				m_q    <= norm_next[NORM_W-1 -: MANT_W];
				frac_q <= '0;
				it_q   <= '0;
			end
			L_SQR: begin
				m_q    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], t[MANT_W]};
				it_q   <= it_q + ITER_W'(1);
			end
			L_DONE: begin
				step_q <= '0;
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

endmodule

[rtl/core/armd_back.sv]
// Back end: takes a closed window from the queue; a zero sum or count gives
// the floor, else log2 of both is scaled to centi-dB. Holds the result beat; uses armd_pkg.
module armd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  armd_pkg::win_t                q_data,
	output logic                          q_ready,
	output armd_pkg::log_req_t            log_req,
	input  armd_pkg::log_rsp_t            log_rsp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [armd_pkg::LEVEL_W-1:0]  out_level,
	output logic                          out_floor
);
	import armd_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;
	win_t                ent_q;
	logic [LOG_W-1:0]    ls_q;
	logic [LOG_W-1:0]    ln_q;
	logic [PROD_W-1:0]   p_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                floor_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic                out_floor_q;

	logic                zero_in;
	logic [DIFF_W-1:0]   top;
	logic                ge;
	logic [DIFF_W-1:0]   d;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     rnd_sum;
	logic [RND_W-1:0]    r;
	logic [RND_W-1:0]    r_clamp;
	logic                load_out;

	assign zero_in  = (ent_q.sum == '0) || (ent_q.cnt == '0);
	assign top      = DIFF_W'(ln_q) + TOP_OFFSET;
	assign ge       = DIFF_W'(ls_q) >= top;
	assign d        = top - DIFF_W'(ls_q);
	assign prod     = d * CENTI_DB_PER_LOG2;
	assign rnd_sum  = {1'b0, p_q} + (PROD_W+1)'(64'd1 << (RND_SH - 1));
	assign r        = rnd_sum[PROD_W:RND_SH];
	assign r_clamp  = (r > MAX_ATTEN) ? MAX_ATTEN : r;
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;
	assign out_floor = out_floor_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) state_d = B_SS;
			B_SS:   state_d = zero_in ? B_OUT : B_LS;
			B_LS:   if (log_rsp.done) state_d = B_SN;
			B_SN:   state_d = B_LN;
			B_LN:   if (log_rsp.done) state_d = B_MUL;
			B_MUL:  state_d = B_RND;
			B_RND:  state_d = B_OUT;
			B_OUT:  if (load_out) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_ready       = state_q == B_IDLE;
		log_req.start = ((state_q == B_SS) && !zero_in) || (state_q == B_SN);
		log_req.x     = (state_q == B_SN) ? NORM_W'(ent_q.cnt) : NORM_W'(ent_q.sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			ent_q <= q_data;
		end
		if (state_q == B_SS) begin
			level_q <= FLOOR_LEVEL;
			floor_q <= 1'b1;
		end
		if ((state_q == B_LS) && log_rsp.done) begin
			ls_q <= log_rsp.value;
		end
		if ((state_q == B_LN) && log_rsp.done) begin
			ln_q <= log_rsp.value;
		end
		if (state_q == B_MUL) begin
			p_q     <= ge ? '0 : prod;
			floor_q <= 1'b0;
		end
		if (state_q == B_RND) begin
			level_q <= LEVEL_W'(-(LEVEL_W'(r_clamp)));
		end
		if (load_out) begin
			out_level_q <= level_q;
			out_floor_q <= floor_q;
		end
	end

endmodule

[rtl/core/audio_rms_dbfs_meter_unit.sv]
// The window-end beat passes the front register and the two-entry queue, which absorbs
// short windows; the back end then runs log2 of sum and count and presents the result.
// One sample beat per cycle unless a window-end beat meets a full queue.
// Reset: arst_n clears sums, count, queue and all handshake state at once.
// Top level of the RMS dBFS meter; instantiates front, queue, log2 and back.
// Depends on armd_pkg.
module audio_rms_dbfs_meter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [14:0] level_centi_db, [15] zero pad
	output logic        m_tuser    // [0] floor_used
);
	import armd_pkg::*;

	logic               push;
	win_t               push_data;
	logic               q_full;
	logic               q_valid;
	win_t               q_data;
	logic               q_ready;
	log_req_t           log_req;
	log_rsp_t           log_rsp;
	logic [LEVEL_W-1:0] level;

	armd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	armd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.rd_ready (q_ready)
	);

	armd_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.rsp    (log_rsp)
	);

	armd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_ready   (q_ready),
		.log_req   (log_req),
		.log_rsp   (log_rsp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_level (level),
		.out_floor (m_tuser)
	);

	assign m_tdata = {1'b0, level};

endmodule

[rtl/core/armd_checker.sv]
// Port-level checker for the RMS dBFS meter, bound to the top level.
// Depends only on the top level's port names.
module armd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_floor_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[14:0] == 15'h58F0)
		else $error("floor flag without -100 dB level");

	a_level_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[15] && (m_tdata[14] || m_tdata[14:0] == 15'd0))
		else $error("positive level or nonzero pad bit");

	a_no_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid}) && (!m_tvalid || !$isunknown({m_tdata, m_tuser})))
		else $error("unknown handshake or result value");

endmodule

bind audio_rms_dbfs_meter_unit armd_checker u_armd_checker (.*);
